[rtl/core/gfmdp_pkg.sv]
// Shared types, codes and constants for the GF(2^m) multiply/divide/power unit.
// No dependencies.
`timescale 1ns / 1ps

package gfmdp_pkg;

    localparam int DATA_W         = 16;   // field element / log width
    localparam int EXP_W          = 16;   // exponent width for power
    localparam int DEG_W          = 5;
    localparam int POLY_W         = 17;
    localparam int MAX_DEGREE_DEF = 16;
    localparam int CFG_IDX_W      = 1;

    typedef enum logic [1:0] {
        MODE_MUL = 2'd0,
        MODE_DIV = 2'd1,
        MODE_POW = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    // how the final result is formed
    typedef enum logic [1:0] {
        KIND_ZERO   = 2'd0,
        KIND_ONE    = 2'd1,
        KIND_LOOKUP = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE = 1'b0,
        REG_POLY   = 1'b1
    } cfg_reg_t;

    // one pipeline slot travelling along the cell chain
    typedef struct packed {
        logic              valid;
        mode_t             mode;
        kind_t             kind;
        status_t           status;
        logic [EXP_W-1:0]  expo;
        logic [DATA_W-1:0] la;
        logic [DATA_W-1:0] lb;
        logic [DATA_W-1:0] acc;
    } slot_t;

    // default primitive polynomial for each degree
    function automatic logic [POLY_W-1:0] default_poly(input logic [DEG_W-1:0] m);
        logic [POLY_W-1:0] p;
        begin
            case (m)
                5'd1:    p = 17'h00003;
                5'd2:    p = 17'h00007;
                5'd3:    p = 17'h0000b;
                5'd4:    p = 17'h00013;
                5'd5:    p = 17'h00025;
                5'd6:    p = 17'h00043;
                5'd7:    p = 17'h00089;
                5'd8:    p = 17'h0011d;
                5'd9:    p = 17'h00211;
                5'd10:   p = 17'h00409;
                5'd11:   p = 17'h00805;
                5'd12:   p = 17'h01053;
                5'd13:   p = 17'h0201b;
                5'd14:   p = 17'h04443;
                5'd15:   p = 17'h08003;
                5'd16:   p = 17'h1100b;
                default: p = 17'h00000;
            endcase
            return p;
        end
    endfunction

    // x + y modulo 2^m-1 with end-around carry; inputs at most mask
    function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] x,
                                                  input logic [DATA_W-1:0] y,
                                                  input logic [DATA_W-1:0] mask);
        logic [DATA_W:0] s;
        logic            carry;
        begin
            s     = {1'b0, x} + {1'b0, y};
            carry = |(s & ~{1'b0, mask});
            return (s[DATA_W-1:0] & mask) + {{(DATA_W-1){1'b0}}, carry};
        end
    endfunction

endpackage

[rtl/core/gfmdp_in_if.sv]
// Request channel of the GF(2^m) unit: mode and two operands.
// Depends on gfmdp_pkg.
`timescale 1ns / 1ps

interface gfmdp_in_if
    import gfmdp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [DATA_W-1:0] operand_a;
    logic [EXP_W-1:0]  operand_b;

    modport source (output valid, mode, operand_a, operand_b, input ready);
    modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

[rtl/core/gfmdp_out_if.sv]
// Result channel of the GF(2^m) unit: field element and status.
// Depends on gfmdp_pkg.
`timescale 1ns / 1ps

interface gfmdp_out_if
    import gfmdp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result;
    logic [1:0]        status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

[rtl/core/gfmdp_cell.sv]
// One cell of the exponent chain: handles one exponent bit, MSB first,
// acc = 2*acc + bit*log(a) mod 2^m-1. Depends on gfmdp_pkg.
`timescale 1ns / 1ps

module gfmdp_cell
    import gfmdp_pkg::*;
#(
    parameter int BIT_POS = EXP_W - 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [DATA_W-1:0] mask,
    input  slot_t             slot_in,
    output slot_t             slot_out
);

    logic [DATA_W-1:0] top_bit;
    logic [DATA_W-1:0] rot;
    logic [DATA_W-1:0] acc_next;
    slot_t             slot_reg;
    slot_t             slot_next;

    // rotate left within m bits is doubling mod 2^m-1
    always_comb
    begin
        top_bit = mask ^ (mask >> 1);
        rot     = ((slot_in.acc << 1) & mask) |
                  {{(DATA_W-1){1'b0}}, |(slot_in.acc & top_bit)};
        acc_next = slot_in.expo[BIT_POS] ? add_mod(rot, slot_in.la, mask) : rot;
        slot_next     = slot_in;
        slot_next.acc = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (adv)
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

[rtl/core/gfmdp_tables.sv]
// Configuration registers, log/antilog memories and their build sequencer.
// Depends on gfmdp_pkg.
`timescale 1ns / 1ps

module gfmdp_tables
    import gfmdp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [POLY_W-1:0]     cfg_data,
    output logic [DATA_W-1:0]     mask,
    output logic                  built,
    input  logic                  log_rd_en,
    input  logic [MAX_DEGREE-1:0] log_addr_a,
    input  logic [MAX_DEGREE-1:0] log_addr_b,
    output logic [DATA_W-1:0]     log_data_a,
    output logic [DATA_W-1:0]     log_data_b,
    input  logic                  alog_rd_en,
    input  logic [MAX_DEGREE-1:0] alog_addr,
    output logic [DATA_W-1:0]     alog_data
);

    localparam int DEPTH = 1 << MAX_DEGREE;

    typedef enum logic [2:0] {
        BLD_IDLE  = 3'b001,
        BLD_CLEAR = 3'b010,
        BLD_FILL  = 3'b100
    } bld_state_t;

    logic [DEG_W-1:0]      degree_reg;
    logic [POLY_W-1:0]     poly_reg;
    bld_state_t            state_reg, state_next;
    logic [MAX_DEGREE-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]     x_reg, x_next;

    logic [DEG_W-1:0]      eff_m;
    logic [POLY_W-1:0]     poly_sel;
    logic [DATA_W-1:0]     low;
    logic [DATA_W-1:0]     x_step;
    logic [MAX_DEGREE-1:0] mask_a;

    logic                  log_we, alog_we;
    logic [MAX_DEGREE-1:0] log_wa, alog_wa;
    logic [DATA_W-1:0]     log_wd, alog_wd;

    logic [DATA_W-1:0] log_mem  [DEPTH];
    logic [DATA_W-1:0] alog_mem [DEPTH];

    // effective degree, mask and reduction polynomial
    always_comb
    begin
        if (degree_reg == '0)
            eff_m = DEG_W'(1);
        else if (degree_reg > DEG_W'(MAX_DEGREE))
            eff_m = DEG_W'(MAX_DEGREE);
        else
            eff_m = degree_reg;
        mask     = DATA_W'((17'd1 << eff_m) - 17'd1);
        poly_sel = (poly_reg == '0) ? default_poly(eff_m) : poly_reg;
        low      = poly_sel[DATA_W-1:0] & mask;
        mask_a   = mask[MAX_DEGREE-1:0];
        x_step   = ((x_reg << 1) & mask) ^ ((|(x_reg & (mask ^ (mask >> 1)))) ? low : '0);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= DEG_W'(8);
            poly_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEGREE: degree_reg <= cfg_data[DEG_W-1:0];
                REG_POLY:   poly_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // build sequencer: clear log entries, then step alpha^i
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        log_we     = 1'b0;
        log_wa     = cnt_reg;
        log_wd     = '0;
        alog_we    = 1'b0;
        alog_wa    = cnt_reg;
        alog_wd    = DATA_W'(1);
        unique case (state_reg)
            BLD_IDLE: ;
            BLD_CLEAR:
            begin
                log_we  = 1'b1;
                alog_we = (cnt_reg == '0);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mask_a)
                begin
                    cnt_next = MAX_DEGREE'(1);
                    x_next   = DATA_W'(1);
                    state_next = (mask > DATA_W'(1)) ? BLD_FILL : BLD_IDLE;
                end
            end
            BLD_FILL:
            begin
                // log of one stays 0
                log_we  = (x_step != DATA_W'(1));
                log_wa  = x_step[MAX_DEGREE-1:0];
                log_wd  = DATA_W'(cnt_reg);
                alog_we = 1'b1;
                alog_wd = x_step;
                x_next  = x_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mask_a - 1'b1)
                    state_next = BLD_IDLE;
            end
            default: state_next = BLD_IDLE;
        endcase
        if (cfg_we)
        begin
            state_next = BLD_CLEAR;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BLD_CLEAR;
            cnt_reg   <= '0;
            x_reg     <= DATA_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            x_reg     <= x_next;
        end
    end

    assign built = (state_reg == BLD_IDLE) && !cfg_we;

    // log memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (log_we)
            log_mem[log_wa] <= log_wd;
        if (log_rd_en)
        begin
            log_data_a <= log_mem[log_addr_a];
            log_data_b <= log_mem[log_addr_b];
        end
    end

    // antilog memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (alog_we)
            alog_mem[alog_wa] <= alog_wd;
        if (alog_rd_en)
            alog_data <= alog_mem[alog_addr];
    end

endmodule

[rtl/core/gf2m_mul_div_pow_unit_core.sv]
// Top level of the GF(2^m) multiply/divide/power unit.
// Depends on gfmdp_pkg, gfmdp_in_if, gfmdp_out_if, gfmdp_tables, gfmdp_cell.
`timescale 1ns / 1ps

// Multiply, divide and power over GF(2^m), m = 1..16, by log/antilog tables.
// One request per clock is accepted unless the result side stalls; each result
// passes a log read, one cell per exponent bit, and the antilog read together
// with the output register.
// After reset and after every configuration write the tables are rebuilt
// before requests are taken: every log table entry is cleared, then the
// generator is stepped through the antilog table; ready stays low meanwhile.
// Configure only while idle.
module gf2m_mul_div_pow_unit_core
    import gfmdp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POLY_W-1:0]    cfg_data,
    gfmdp_in_if.sink             in_chan,
    gfmdp_out_if.source          out_chan
);

    logic              adv;
    logic              built;
    logic              accept;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] la, lb, alog_data;

    slot_t             s0_reg, s0_next;
    slot_t             chain [EXP_W+1];
    slot_t             last;
    logic [DATA_W-1:0] idx;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    status_t           out_status_reg;

    mode_t             req_mode;
    logic              err_a, err_b;

    assign adv    = !out_valid_reg || out_chan.ready;
    assign accept = in_chan.valid && in_chan.ready;
    assign in_chan.ready = built && adv;

    gfmdp_tables #(.MAX_DEGREE(MAX_DEGREE)) u_tables (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mask       (mask),
        .built      (built),
        .log_rd_en  (adv),
        .log_addr_a (in_chan.operand_a[MAX_DEGREE-1:0]),
        .log_addr_b (in_chan.operand_b[MAX_DEGREE-1:0]),
        .log_data_a (la),
        .log_data_b (lb),
        .alog_rd_en (adv),
        .alog_addr  (idx[MAX_DEGREE-1:0]),
        .alog_data  (alog_data)
    );

    // request decode: range check, special cases
    always_comb
    begin
        req_mode = mode_t'(in_chan.mode);
        err_a    = |(in_chan.operand_a & ~mask);
        err_b    = |(in_chan.operand_b & ~mask) &&
                   (req_mode == MODE_MUL || req_mode == MODE_DIV);
        s0_next        = '0;
        s0_next.valid  = accept;
        s0_next.mode   = req_mode;
        s0_next.expo   = in_chan.operand_b;
        s0_next.kind   = KIND_ZERO;
        s0_next.status = ST_OK;
        if (err_a || err_b)
            s0_next.status = ST_RANGE;
        else
        begin
            case (req_mode)
                MODE_MUL:
                    if (in_chan.operand_a != '0 && in_chan.operand_b != '0)
                        s0_next.kind = KIND_LOOKUP;
                MODE_DIV:
                    if (in_chan.operand_b == '0)
                        s0_next.status = ST_DIV_ZERO;
                    else if (in_chan.operand_a != '0)
                        s0_next.kind = KIND_LOOKUP;
                MODE_POW:
                    if (in_chan.operand_b == '0)
                        s0_next.kind = KIND_ONE;
                    else if (in_chan.operand_a != '0)
                        s0_next.kind = KIND_LOOKUP;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_reg <= '0;
        else if (adv)
            s0_reg <= s0_next;
    end

    // head of the chain picks up the log reads
    always_comb
    begin
        chain[0]     = s0_reg;
        chain[0].la  = la;
        chain[0].lb  = lb;
        chain[0].acc = '0;
    end

    // exponent chain, one cell per bit, MSB first
    for (genvar k = 0; k < EXP_W; k++)
    begin : g_cell
        gfmdp_cell #(.BIT_POS(EXP_W - 1 - k)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .mask     (mask),
            .slot_in  (chain[k]),
            .slot_out (chain[k+1])
        );
    end

    // antilog index by operation, zero residue kept as 0
    always_comb
    begin
        last = chain[EXP_W];
        case (last.mode)
            MODE_MUL: idx = add_mod(last.la, last.lb, mask);
            MODE_DIV: idx = add_mod(last.la, ~last.lb & mask, mask);
            default:  idx = last.acc;
        endcase
        if (idx == mask)
            idx = '0;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_ZERO;
            out_status_reg <= ST_OK;
        end
        else if (adv)
        begin
            out_valid_reg  <= last.valid;
            out_kind_reg   <= last.kind;
            out_status_reg <= last.status;
        end
    end

    assign out_chan.valid  = out_valid_reg;
    assign out_chan.status = out_status_reg;
    always_comb
    begin
        case (out_kind_reg)
            KIND_LOOKUP: out_chan.result = alog_data;
            KIND_ONE:    out_chan.result = DATA_W'(1);
            default:     out_chan.result = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    // no request taken while the tables are rebuilt
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_chan.ready)
        else $error("request accepted during table rebuild");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && out_chan.status != ST_OK) |-> out_chan.result == '0)
        else $error("nonzero result with error status");

    // a stalled result does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && !out_chan.ready) |=>
            (out_chan.valid && $stable(out_chan.result) && $stable(out_chan.status)))
        else $error("stalled result changed");
`endif

endmodule

[tb/gf2m_mul_div_pow_unit_core_tb.sv]
// Self-checking regression for the GF(2^m) multiply/divide/power unit.
// Depends on gfmdp_pkg, gfmdp_in_if, gfmdp_out_if and gf2m_mul_div_pow_unit_core.
`timescale 1ns / 1ps

module gf2m_mul_div_pow_unit_core_tb;
    import gfmdp_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] result;
        status_t           status;
    } gf_answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POLY_W-1:0] cfg_data;

    gfmdp_in_if  in_chan ();
    gfmdp_out_if out_chan ();

    gf2m_mul_div_pow_unit_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (in_chan),
        .out_chan  (out_chan)
    );

    // shadow of the field configuration and its tables
    logic [DEG_W-1:0]  sh_degree;
    logic [POLY_W-1:0] sh_poly;
    int unsigned       fld_m;
    int unsigned       fld_order;
    logic [DATA_W-1:0] alog_tab [65536];
    logic [DATA_W-1:0] log_tab  [65536];

    gf_answer_t answers_due [$];
    int         fail_count;
    bit         hold_off_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("gf2m_mul_div_pow_unit_core regression: fail");
        $finish;
    end

    // rebuild the shadow tables from the shadow registers
    task automatic rebuild_field();
        int unsigned poly, top, low, x;
        begin
            fld_m = 32'(sh_degree);
            if (fld_m < 1) fld_m = 1;
            if (fld_m > 16) fld_m = 16;
            fld_order = (1 << fld_m) - 1;
            poly = 32'(sh_poly);
            if (poly == 0) poly = 32'(default_poly(fld_m[DEG_W-1:0]));
            top = 1 << fld_m;
            low = poly & (top - 1);
            alog_tab = '{default: '0};
            log_tab  = '{default: '0};
            x = 1;
            alog_tab[0] = 16'd1;
            for (int unsigned i = 1; i < fld_order; i++)
            begin
                x = x << 1;
                if ((x & top) != 0) x = (x ^ top) ^ low;
                x = x & (top - 1);
                alog_tab[i[DATA_W-1:0]] = x[DATA_W-1:0];
                log_tab[x[DATA_W-1:0]]  = i[DATA_W-1:0];
            end
            log_tab[1] = '0;
        end
    endtask

    function automatic gf_answer_t gf_compute(mode_t op, logic [DATA_W-1:0] a,
                                             logic [EXP_W-1:0] b);
        gf_answer_t  ans;
        longint unsigned idx;
        longint unsigned n;
        begin
            n = fld_order;
            ans.result = '0;
            ans.status = ST_OK;
            if ((a >> fld_m) != 0 || ((op == MODE_MUL || op == MODE_DIV) && (b >> fld_m) != 0))
                ans.status = ST_RANGE;
            else if (op == MODE_MUL)
            begin
                if (a != 0 && b != 0)
                begin
                    idx = (longint'(log_tab[a]) + log_tab[b]) % n;
                    ans.result = alog_tab[idx[DATA_W-1:0]];
                end
            end
            else if (op == MODE_DIV)
            begin
                if (b == 0)
                    ans.status = ST_DIV_ZERO;
                else if (a != 0)
                begin
                    idx = (longint'(log_tab[a]) + n - (log_tab[b] % n)) % n;
                    ans.result = alog_tab[idx[DATA_W-1:0]];
                end
            end
            else if (op == MODE_POW)
            begin
                if (b == 0)
                    ans.result = 16'd1;
                else if (a != 0)
                begin
                    idx = ((log_tab[a] % n) * (b % n)) % n;
                    ans.result = alog_tab[idx[DATA_W-1:0]];
                end
            end
            return ans;
        end
    endfunction

    // offer one request after a random gap, record its answer at acceptance
    task automatic send_request(mode_t op, logic [DATA_W-1:0] a, logic [EXP_W-1:0] b,
                                bit no_gap = 0);
        int gap;
        begin
            gap = no_gap ? 0 : int'($urandom_range(0, 14));
            if (gap > 0)
            begin
                in_chan.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_chan.valid     <= 1'b1;
            in_chan.mode      <= op;
            in_chan.operand_a <= a;
            in_chan.operand_b <= b;
            do @(posedge clk); while (!in_chan.ready);
            answers_due.push_back(gf_compute(op, a, b));
        end
    endtask

    // wait until the pipe is empty, then let the tail drain
    task automatic wait_idle();
        begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
            while (answers_due.size() != 0) @(posedge clk);
            repeat (30) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [POLY_W-1:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            if (idx == REG_DEGREE) sh_degree = val[DEG_W-1:0];
            else sh_poly = val;
            rebuild_field();
            repeat (3) @(posedge clk);
            while (!in_chan.ready) @(posedge clk);
        end
    endtask

    task automatic set_field(logic [POLY_W-1:0] deg, logic [POLY_W-1:0] poly,
                             bit poly_first);
        begin
            wait_idle();
            if (poly_first)
            begin
                write_reg(REG_POLY, poly);
                write_reg(REG_DEGREE, deg);
            end
            else
            begin
                write_reg(REG_DEGREE, deg);
                write_reg(REG_POLY, poly);
            end
        end
    endtask

    // corners of the default GF(2^8)
    task automatic test_directed();
        begin
            send_request(MODE_MUL, 16'h0000, 16'h0037);
            send_request(MODE_MUL, 16'h0045, 16'h0000);
            send_request(MODE_MUL, 16'h0001, 16'h0001);
            send_request(MODE_MUL, 16'h00ff, 16'h00ff);
            send_request(MODE_MUL, 16'h0100, 16'h0003);
            send_request(MODE_MUL, 16'h0003, 16'hffff);
            send_request(MODE_DIV, 16'h0055, 16'h0000);
            send_request(MODE_DIV, 16'h0000, 16'h0005);
            send_request(MODE_DIV, 16'h00ff, 16'h00ff);
            send_request(MODE_DIV, 16'h0001, 16'h0080);
            send_request(MODE_DIV, 16'h0012, 16'h0100);
            send_request(MODE_DIV, 16'hffff, 16'h0000);
            send_request(MODE_POW, 16'h0000, 16'h0000);
            send_request(MODE_POW, 16'h0000, 16'h0005);
            send_request(MODE_POW, 16'h00a5, 16'h0000);
            send_request(MODE_POW, 16'h0002, 16'h00ff);
            send_request(MODE_POW, 16'h0002, 16'hffff);
            send_request(MODE_POW, 16'h01ff, 16'h0002);
            send_request(MODE_POW, 16'h00ff, 16'h8000);
            send_request(MODE_NOP, 16'h0012, 16'h0034);
            send_request(MODE_NOP, 16'hff00, 16'hffff);
        end
    endtask

    // random traffic: mostly in-field operands, some stray ones
    task automatic test_random(int count);
        logic [DATA_W-1:0] a, b, mask;
        mode_t op;
        begin
            mask = fld_order[DATA_W-1:0];
            for (int i = 0; i < count; i++)
            begin
                case ($urandom_range(0, 19))
                    0:       op = MODE_NOP;
                    1, 2, 3, 4, 5, 6:  op = MODE_MUL;
                    7, 8, 9, 10, 11, 12: op = MODE_DIV;
                    default: op = MODE_POW;
                endcase
                a = DATA_W'($urandom()) & mask;
                b = DATA_W'($urandom()) & mask;
                if ($urandom_range(0, 9) == 0) a = DATA_W'($urandom());
                if ($urandom_range(0, 9) == 0) b = DATA_W'($urandom());
                if (op == MODE_POW && $urandom_range(0, 1) != 0) b = DATA_W'($urandom());
                if ($urandom_range(0, 15) == 0) a = '0;
                if ($urandom_range(0, 15) == 0) b = '0;
                send_request(op, a, b);
            end
        end
    endtask

    // receiver stalls long while requests keep coming back to back
    task automatic test_backpressure();
        begin
            hold_off_req = 1'b1;
            for (int i = 0; i < 60; i++)
                send_request(mode_t'($urandom_range(0, 2)),
                             DATA_W'($urandom() & fld_order),
                             EXP_W'($urandom() & fld_order), 1'b1);
        end
    endtask

    // result side: random stalls, check each result in order
    initial
    begin
        gf_answer_t want;
        int stall;
        out_chan.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 14));
            if ($urandom_range(0, 5) == 0) stall = 0;
            if (hold_off_req)
            begin
                stall = 400;
                hold_off_req = 1'b0;
            end
            if (stall > 0)
            begin
                out_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_chan.ready <= 1'b1;
            do @(posedge clk); while (!out_chan.valid);
            if (answers_due.size() == 0)
            begin
                $error("result with no request outstanding: result %h status %0d",
                       out_chan.result, out_chan.status);
                fail_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (out_chan.result !== want.result)
                begin
                    $error("result: expected %h, actual %h", want.result, out_chan.result);
                    fail_count++;
                end
                if (out_chan.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_chan.status);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        fail_count        = 0;
        hold_off_req      = 1'b0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_DEGREE;
        cfg_data          <= '0;
        in_chan.valid     <= 1'b0;
        in_chan.mode      <= MODE_MUL;
        in_chan.operand_a <= '0;
        in_chan.operand_b <= '0;
        sh_degree = 5'd8;
        sh_poly   = '0;
        rebuild_field();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_chan.ready) @(posedge clk);

        test_directed();
        test_random(250);
        test_backpressure();
        set_field(17'd1, 17'd0, 1'b0);
        test_random(120);
        set_field(17'd2, 17'h00007, 1'b0);
        test_random(120);
        set_field(17'd4, 17'h00019, 1'b0);
        test_random(150);
        set_field(17'd16, 17'd0, 1'b1);
        test_random(250);
        set_field(17'd3, 17'h1fff9, 1'b0);
        test_random(150);
        set_field(17'd0, 17'h00000, 1'b1);
        test_random(100);
        set_field(17'd12, 17'h01053, 1'b0);
        test_random(200);
        set_field(17'd7, 17'h00083, 1'b0);
        test_random(150);
        set_field(17'd5, 17'h0003d, 1'b0);
        test_random(150);
        set_field(17'd31, 17'h1100b, 1'b1);
        test_random(200);

        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("gf2m_mul_div_pow_unit_core regression: pass");
        else
            $display("gf2m_mul_div_pow_unit_core regression: fail");
        $finish;
    end

endmodule
